// ===== rtl/pcxrle_pkg.sv =====
// Shared types and constants of the PCX run-length planar decoder.
// Used by every module of the block; depends on nothing.
package pcxrle_pkg;

   // Run header bytes start at this code; the low bits hold the run length
   localparam int unsigned RUN_BITS = 6;
   localparam logic [7:0] RUN_HEADER = 8'hC0;

   // Color planes per scanline (red, green, blue)
   localparam logic [1:0] PLANES = 2'd3;

   // Default depth of the command queue between front and back
   localparam int unsigned CMDQ_DEPTH_DEF = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_LINE = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd2;

   // One expansion command: a value and how many times to emit it
   typedef struct packed {
      logic [7:0]          value;
      logic [RUN_BITS-1:0] count;
   } cmd_type;

   // Geometry registers
   typedef struct packed {
      logic [15:0] bytes_per_line;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

endpackage

// ===== rtl/pcx_rle_planar_decoder.sv =====
// Top level of the PCX run-length planar decoder: geometry registers,
// front end, command queue and back end. Depends on pcxrle_pkg.
//
// Usage:
//  Input side is a queue: drive req_stream_byte and req_push; a word is
//  taken at a clock edge with req_push high and req_full low. One word is
//  taken per cycle while the command queue has room.
//  Result side is a queue: while rsp_empty is low the oldest result sits on
//  the rsp_ ports; it is taken at an edge with rsp_pop high.
//  A literal word yields one result, a run header none, and the value word
//  after it yields the whole run, one result per cycle from the back end.
//  A literal passes the queue write at the accepting edge, the back-end load
//  and the result register before its result is on the ports.
//  Sustained rate is one result per cycle, set by the single expansion unit
//  in the back end; long runs fill the command queue and then hold req_full
//  high. If the receiver stalls, the result register holds and the back end
//  and then the queue stop; no result is lost.
//  Geometry is written on the csr_ port (always ready) while the block is
//  idle; the user must ensure this, the block does not check. Synchronous reset
//  clears position, run state and queue; registers go to 1. After the last
//  byte of the image all later words are taken and dropped until reset.
module pcx_rle_planar_decoder #(
   parameter int unsigned CMDQ_DEPTH = pcxrle_pkg::CMDQ_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Compressed byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_stream_byte,
   // Decoded result output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_column,
   output logic [1:0]  rsp_plane,
   output logic [15:0] rsp_out_row,
   output logic        rsp_in_image,
   output logic        rsp_run_last,
   output logic        rsp_image_done,
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   pcxrle_pkg::cfg_type cfg_ff;
   pcxrle_pkg::cfg_type cfg_in;
   pcxrle_pkg::cmd_type front_cmd;
   pcxrle_pkg::cmd_type head_cmd;
   logic                front_push;
   logic                cmdq_full;
   logic                cmdq_valid;
   logic                cmdq_pop;

   assign csr_ready = 1'b1;

   // Write geometry registers; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pcxrle_pkg::CSR_BYTES_PER_LINE: cfg_in.bytes_per_line = csr_data;
            pcxrle_pkg::CSR_IMAGE_WIDTH:    cfg_in.image_width    = csr_data;
            pcxrle_pkg::CSR_IMAGE_HEIGHT:   cfg_in.image_height   = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_line <= 16'd1;
         cfg_ff.image_width    <= 16'd1;
         cfg_ff.image_height   <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcxrle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .stream_byte (req_stream_byte),
      .full        (req_full),
      .cmd_full    (cmdq_full),
      .cmd_push    (front_push),
      .cmd         (front_cmd)
   );

   pcxrle_cmdq #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_cmd  (front_cmd),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .head_cmd  (head_cmd),
      .not_empty (cmdq_valid)
   );

   pcxrle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (cmdq_valid),
      .cmd             (head_cmd),
      .cmd_pop         (cmdq_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_column      (rsp_column),
      .rsp_plane       (rsp_plane),
      .rsp_out_row     (rsp_out_row),
      .rsp_in_image    (rsp_in_image),
      .rsp_run_last    (rsp_run_last),
      .rsp_image_done  (rsp_image_done)
   );

`ifndef NO_ASSERTIONS
   // The end of the image always closes the run that reached it
   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_image_done) |-> rsp_run_last)
      else $error("image_done without run_last");

   // Padding flag agrees with the visible width
   a_in_image_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_in_image == (rsp_column < cfg_ff.image_width)))
      else $error("in_image does not match column");

   // Plane counter never leaves red, green, blue
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_plane != 2'd3))
      else $error("plane out of range");
`endif

endmodule

// ===== rtl/pcxrle_front.sv =====
// Front end: accepts stream bytes, splits run headers from literals and
// queues expansion commands. Depends on pcxrle_pkg.
module pcxrle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          stream_byte,
   output logic                full,
   input  logic                cmd_full,
   output logic                cmd_push,
   output pcxrle_pkg::cmd_type cmd
);

   logic                                await_value_ff;
   logic                                await_value_in;
   logic [pcxrle_pkg::RUN_BITS-1:0]     pending_run_ff;
   logic [pcxrle_pkg::RUN_BITS-1:0]     pending_run_in;
   logic                                accept;
   logic                                is_header;

   assign full      = cmd_full;
   assign accept    = push && !cmd_full;
   assign is_header = (stream_byte >= pcxrle_pkg::RUN_HEADER);

   // Classify the word: value of a pending run, literal, or run header
   always_comb begin
      await_value_in = await_value_ff;
      pending_run_in = pending_run_ff;
      cmd_push       = 1'b0;
      cmd.value      = stream_byte;
      cmd.count      = pcxrle_pkg::RUN_BITS'(1);
      if (accept) begin
         if (await_value_ff) begin
            await_value_in = 1'b0;
            pending_run_in = '0;
            cmd.count      = pending_run_ff;
            // drop zero-length runs here
            cmd_push       = (pending_run_ff != '0);
         end else if (!is_header) begin
            cmd_push = 1'b1;
         end else begin
            pending_run_in = stream_byte[pcxrle_pkg::RUN_BITS-1:0];
            await_value_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_value_ff <= 1'b0;
         pending_run_ff <= '0;
      end else begin
         await_value_ff <= await_value_in;
         pending_run_ff <= pending_run_in;
      end
   end

endmodule

// ===== rtl/pcxrle_cmdq.sv =====
// Short command queue between front and back ends.
// Depends on pcxrle_pkg for the command type.
module pcxrle_cmdq #(
   parameter int unsigned DEPTH = pcxrle_pkg::CMDQ_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcxrle_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output pcxrle_pkg::cmd_type head_cmd,
   output logic                not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   pcxrle_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/pcxrle_back.sv =====
// Back end: expands queued commands one byte per cycle while not stalled,
// tracks column, plane and row, holds the result word. Depends on pcxrle_pkg.
module pcxrle_back (
   input  logic                clock,
   input  logic                reset,
   input  pcxrle_pkg::cfg_type cfg,
   input  logic                cmd_valid,
   input  pcxrle_pkg::cmd_type cmd,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_pixel_value,
   output logic [15:0]         rsp_column,
   output logic [1:0]          rsp_plane,
   output logic [15:0]         rsp_out_row,
   output logic                rsp_in_image,
   output logic                rsp_run_last,
   output logic                rsp_image_done
);

   // Current command
   logic                            cur_valid_ff;
   logic                            cur_valid_in;
   logic [7:0]                      cur_value_ff;
   logic [7:0]                      cur_value_in;
   logic [pcxrle_pkg::RUN_BITS-1:0] cur_left_ff;
   logic [pcxrle_pkg::RUN_BITS-1:0] cur_left_in;
   // Position of the next byte
   logic [15:0]                     col_ff;
   logic [15:0]                     col_in;
   logic [1:0]                      plane_ff;
   logic [1:0]                      plane_in;
   logic [15:0]                     row_ff;
   logic [15:0]                     row_in;
   logic                            finished_ff;
   logic                            finished_in;
   // Result word
   logic                            out_valid_ff;
   logic                            out_valid_in;

   logic [15:0] bpl_eff;
   logic [15:0] height_eff;
   logic [16:0] col_inc;
   logic [1:0]  plane_inc;
   logic [16:0] row_inc;
   logic        col_wrap;
   logic        plane_wrap;
   logic        row_wrap;
   logic        emit;
   logic        last;
   logic        done;
   logic        load;

   // Zero limits act as one
   assign bpl_eff    = (cfg.bytes_per_line == '0) ? 16'd1 : cfg.bytes_per_line;
   assign height_eff = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;

   // Step the position counters
   assign col_inc    = {1'b0, col_ff} + 17'd1;
   assign col_wrap   = col_inc[16] || (col_inc[15:0] >= bpl_eff);
   assign plane_inc  = plane_ff + 2'd1;
   assign plane_wrap = (plane_inc >= pcxrle_pkg::PLANES);
   assign row_inc    = {1'b0, row_ff} + 17'd1;
   assign row_wrap   = row_inc[16] || (row_inc[15:0] >= height_eff);

   assign emit = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign last = (cur_left_ff == pcxrle_pkg::RUN_BITS'(1));
   assign done = col_wrap && plane_wrap && row_wrap;

   // Take the next command when the current one frees up; drop all after the end
   assign load    = !finished_ff && cmd_valid &&
                    (!cur_valid_ff || (emit && last && !done));
   assign cmd_pop = cmd_valid && (finished_ff || load);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_value_in = cur_value_ff;
      cur_left_in  = cur_left_ff;
      col_in       = col_ff;
      plane_in     = plane_ff;
      row_in       = row_ff;
      finished_in  = finished_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         cur_left_in  = cur_left_ff - pcxrle_pkg::RUN_BITS'(1);
         if (last || done) begin
            cur_valid_in = 1'b0;
         end
         if (col_wrap) begin
            col_in = '0;
            if (plane_wrap) begin
               plane_in = '0;
               if (row_wrap) begin
                  finished_in = 1'b1;
               end
               row_in = row_inc[15:0];
            end else begin
               plane_in = plane_inc;
            end
         end else begin
            col_in = col_inc[15:0];
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         cur_valid_in = 1'b1;
         cur_value_in = cmd.value;
         cur_left_in  = cmd.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_left_ff  <= '0;
         col_ff       <= '0;
         plane_ff     <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_left_ff  <= cur_left_in;
         col_ff       <= col_in;
         plane_ff     <= plane_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the result word
   always_ff @(posedge clock) begin
      cur_value_ff <= cur_value_in;
      if (emit) begin
         rsp_pixel_value <= cur_value_ff;
         rsp_column      <= col_ff;
         rsp_plane       <= plane_ff;
         rsp_out_row     <= height_eff - 16'd1 - row_ff;
         rsp_in_image    <= (col_ff < cfg.image_width);
         rsp_run_last    <= last || done;
         rsp_image_done  <= done;
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule

// ===== tb/pcx_rle_planar_decoder_test.sv =====
// Self-checking testbench of the PCX run-length planar decoder. Drives
// compressed words and geometry writes and checks every decoded word against
// typed rows or the built-in tracker. Depends on pcxrle_pkg and the block.
module pcx_rle_planar_decoder_test;

   // One decoded word as it leaves the block
   typedef struct packed {
      logic [7:0]  value;
      logic [15:0] column;
      logic [1:0]  plane;
      logic [15:0] out_row;
      logic        in_image;
      logic        run_last;
      logic        image_done;
   } pixel_type;

   // One row of the directed stimulus; want is used only where typed is set
   typedef struct packed {
      logic [7:0] word;
      logic       typed;
      pixel_type  want;
   } dir_row_type;

   localparam pixel_type NO_PIXEL = '0;
   localparam int DIR_ROWS = 18;
   localparam int DIR_SPLIT = 2;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_WORDS = 55;
   localparam int SETTLE = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_pixel_value;
   logic [15:0] rsp_column;
   logic [1:0]  rsp_plane;
   logic [15:0] rsp_out_row;
   logic        rsp_in_image;
   logic        rsp_run_last;
   logic        rsp_image_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'd0;

   pcx_rle_planar_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_stream_byte (req_stream_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_column      (rsp_column),
      .rsp_plane       (rsp_plane),
      .rsp_out_row     (rsp_out_row),
      .rsp_in_image    (rsp_in_image),
      .rsp_run_last    (rsp_run_last),
      .rsp_image_done  (rsp_image_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Geometry shadow and decode position of the tracker
   logic [15:0] geo_bpl = 16'd1;
   logic [15:0] geo_width = 16'd1;
   logic [15:0] geo_height = 16'd1;
   logic [5:0]  pend_run = '0;
   logic        await_val = 1'b0;
   logic [15:0] col_q = '0;
   logic [1:0]  plane_q = '0;
   logic [15:0] row_q = '0;
   logic        img_finished = 1'b0;

   pixel_type step_q[$];
   pixel_type pixel_q[$];
   int        mismatches = 0;
   logic      calm = 1'b0;
   int        pop_stall = 0;

   // Place one decoded byte at the current position and advance the position
   task automatic place_byte(input logic [7:0] val, output logic done);
      logic [16:0] eff_bpl;
      logic [16:0] eff_h;
      logic [16:0] nc;
      logic [16:0] nr;
      pixel_type p;
      eff_bpl = (geo_bpl == 16'd0) ? 17'd1 : {1'b0, geo_bpl};
      eff_h = (geo_height == 16'd0) ? 17'd1 : {1'b0, geo_height};
      done = 1'b0;
      p.value = val;
      p.column = col_q;
      p.plane = plane_q;
      p.out_row = eff_h[15:0] - 16'd1 - row_q;
      p.in_image = (col_q < geo_width);
      p.run_last = 1'b0;
      nc = {1'b0, col_q} + 17'd1;
      if (nc[16] || nc >= eff_bpl) begin
         col_q = '0;
         plane_q = plane_q + 2'd1;
         if (plane_q >= pcxrle_pkg::PLANES) begin
            plane_q = '0;
            nr = {1'b0, row_q} + 17'd1;
            row_q = nr[15:0];
            if (nr[16] || nr >= eff_h) begin
               img_finished = 1'b1;
               done = 1'b1;
            end
         end
      end else begin
         col_q = nc[15:0];
      end
      p.image_done = done;
      step_q.push_back(p);
   endtask

   // Expand one accepted word into the decoded words it causes
   task automatic expand_word(input logic [7:0] b);
      logic [7:0] val;
      logic [6:0] count;
      logic       stop;
      pixel_type  t;
      step_q.delete();
      if (img_finished) return;
      if (await_val) begin
         await_val = 1'b0;
         val = b;
         count = {1'b0, pend_run};
         pend_run = '0;
      end else if (b < pcxrle_pkg::RUN_HEADER) begin
         val = b;
         count = 7'd1;
      end else begin
         pend_run = b[5:0];
         await_val = 1'b1;
         return;
      end
      stop = 1'b0;
      while (count > 0 && !stop) begin
         place_byte(val, stop);
         count = count - 7'd1;
      end
      if (step_q.size() > 0) begin
         t = step_q.pop_back();
         t.run_last = 1'b1;
         step_q.push_back(t);
      end
   endtask

   // Offer one word, hold it until taken, then record what it should produce
   task automatic push_word(input logic [7:0] b, input logic typed, input pixel_type want);
      req_push <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_full);
      expand_word(b);
      if (typed) begin
         pixel_q.push_back(want);
      end else begin
         foreach (step_q[k]) pixel_q.push_back(step_q[k]);
      end
   endtask

   // Drop push for a burst of cycles
   task automatic rest(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold the sender until every decoded word has come, then let the block settle
   task automatic quiesce();
      req_push <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one geometry register; valid stays high for the next write
   task automatic csr_word(input logic [1:0] idx, input logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pcxrle_pkg::CSR_BYTES_PER_LINE: geo_bpl = d;
         pcxrle_pkg::CSR_IMAGE_WIDTH:    geo_width = d;
         pcxrle_pkg::CSR_IMAGE_HEIGHT:   geo_height = d;
         default: ;
      endcase
   endtask

   task automatic write_geometry(input logic [15:0] bpl, input logic [15:0] w,
                                 input logic [15:0] h);
      csr_word(pcxrle_pkg::CSR_BYTES_PER_LINE, bpl);
      csr_word(pcxrle_pkg::CSR_IMAGE_WIDTH, w);
      csr_word(pcxrle_pkg::CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // Receiver: pop with random stall bursts, none while calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (calm) begin
         rsp_pop <= 1'b1;
         pop_stall <= 0;
      end else if (pop_stall > 0) begin
         pop_stall <= pop_stall - 1;
         rsp_pop <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         pop_stall <= $urandom_range(0, 12);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Compare each taken word with the oldest expected one
   always @(posedge clock) begin : check_word
      pixel_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected word: value %0d column %0d plane %0d row %0d",
                   rsp_pixel_value, rsp_column, rsp_plane, rsp_out_row);
            mismatches++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_value !== want.value) begin
               $error("pixel_value: expected %0d, actual %0d", want.value, rsp_pixel_value);
               mismatches++;
            end
            if (rsp_column !== want.column) begin
               $error("column: expected %0d, actual %0d", want.column, rsp_column);
               mismatches++;
            end
            if (rsp_plane !== want.plane) begin
               $error("plane: expected %0d, actual %0d", want.plane, rsp_plane);
               mismatches++;
            end
            if (rsp_out_row !== want.out_row) begin
               $error("out_row: expected %0d, actual %0d", want.out_row, rsp_out_row);
               mismatches++;
            end
            if (rsp_in_image !== want.in_image) begin
               $error("in_image: expected %0d, actual %0d", want.in_image, rsp_in_image);
               mismatches++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0d, actual %0d", want.run_last, rsp_run_last);
               mismatches++;
            end
            if (rsp_image_done !== want.image_done) begin
               $error("image_done: expected %0d, actual %0d",
                      want.image_done, rsp_image_done);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: directed words, random phases, then end of image
   initial begin
      dir_row_type dir_tab [DIR_ROWS];
      int          phase;
      int          sent;
      int          pick;
      int          wpick;
      logic [15:0] bpl;
      logic [15:0] w;
      logic [15:0] h;
      logic [16:0] eff;
      logic [7:0]  hdr;

      // Typed rows run at reset geometry: one column, one row
      dir_tab[0]  = {8'h00, 1'b1, 8'h00, 16'd0, 2'd0, 16'd0, 1'b1, 1'b1, 1'b0};
      dir_tab[1]  = {8'hBF, 1'b1, 8'hBF, 16'd0, 2'd1, 16'd0, 1'b1, 1'b1, 1'b0};
      dir_tab[2]  = {8'hC0, 1'b0, NO_PIXEL};   // zero-length run header
      dir_tab[3]  = {8'h55, 1'b0, NO_PIXEL};   // its value: nothing comes out
      dir_tab[4]  = {8'hFF, 1'b0, NO_PIXEL};   // longest run
      dir_tab[5]  = {8'hFF, 1'b0, NO_PIXEL};
      dir_tab[6]  = {8'hC1, 1'b0, NO_PIXEL};
      dir_tab[7]  = {8'h00, 1'b0, NO_PIXEL};
      dir_tab[8]  = {8'hC3, 1'b0, NO_PIXEL};   // header of a run whose value is at or above the header code
      dir_tab[9]  = {8'hC7, 1'b0, NO_PIXEL};
      dir_tab[10] = {8'h01, 1'b0, NO_PIXEL};
      dir_tab[11] = {8'h80, 1'b0, NO_PIXEL};
      dir_tab[12] = {8'h7F, 1'b0, NO_PIXEL};
      dir_tab[13] = {8'h3F, 1'b0, NO_PIXEL};
      dir_tab[14] = {8'hE0, 1'b0, NO_PIXEL};
      dir_tab[15] = {8'h5A, 1'b0, NO_PIXEL};
      dir_tab[16] = {8'hAA, 1'b0, NO_PIXEL};
      dir_tab[17] = {8'h40, 1'b0, NO_PIXEL};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words; grow the image before the first row would close it
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_SPLIT) begin
            quiesce();
            csr_word(pcxrle_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
            csr_valid <= 1'b0;
         end
         if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 13));
         push_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
      end

      // Random phases, each under its own geometry; the last one runs calm
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         quiesce();
         calm = (phase == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
         pick = (phase == 0) ? 0 : (phase == 1) ? 2 : $urandom_range(0, 5);
         case (pick)
            0:       bpl = 16'd0;
            1:       bpl = 16'd1;
            2:       bpl = 16'hFFFF;
            3:       bpl = 16'($urandom_range(2, 8));
            default: bpl = 16'($urandom_range(2, 300));
         endcase
         eff = (bpl == 16'd0) ? 17'd1 : {1'b0, bpl};
         wpick = (phase == 0) ? 2 : (phase == 1) ? 0 : $urandom_range(0, 4);
         case (wpick)
            0:       w = 16'd0;
            1:       w = 16'd1;
            2:       w = 16'hFFFF;
            default: w = (eff > 17'd65531) ? 16'hFFFF : 16'($urandom_range(0, eff + 4));
         endcase
         h = (phase % 2 == 0) ? 16'hFFFF : 16'($urandom_range(32768, 65534));
         write_geometry(bpl, w, h);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if (!calm && $urandom_range(0, 4) == 0) rest($urandom_range(1, 13));
            if ($urandom_range(0, 9) < 6) begin
               push_word(8'($urandom_range(0, 191)), 1'b0, NO_PIXEL);
               sent++;
            end else begin
               hdr = {2'b11, 6'($urandom_range(0, 63))};
               push_word(hdr, 1'b0, NO_PIXEL);
               if (!calm && $urandom_range(0, 4) == 0) rest($urandom_range(1, 13));
               push_word(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
               sent += 2;
            end
         end
      end

      // Close the image with the smallest geometry; later words are dropped
      quiesce();
      write_geometry(16'd1, 16'($urandom_range(0, 3)), 16'd0);
      push_word(8'hFF, 1'b0, NO_PIXEL);
      push_word(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
      repeat (20) push_word(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
      quiesce();
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
